// File: rtl/wies_pkg.sv
// Shared constants and types for the information element search block.
`default_nettype none

package wies_pkg;

    // Longest buffer that is scanned; later bytes only raise overrun.
    localparam int MAX_BUFFER_BYTES = 4096;
    // The byte position must be able to hold MAX_BUFFER_BYTES itself.
    localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int OFFSET_W         = 12;
    localparam int CFG_DATA_W       = 24;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [7:0] VENDOR_SPEC_ID = 8'd221;
    localparam logic [7:0] VENDOR_MIN_LEN = 8'd6;
    // OUI (three bytes) plus the type byte are captured from the body.
    localparam logic [7:0] VENDOR_HDR_LEN = 8'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_OUI = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUI_TYPE   = 2'd3;

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [POS_W-1:0]    pos_t;

endpackage

`default_nettype wire

// File: rtl/wlan_info_element_search.sv
// Top level of the streamed 802.11 information element search.
`default_nettype none

// Usage
//   Requests arrive on the input channel (in_valid/in_ready), one buffer byte
//   each, with last_byte marking the final byte of a buffer. On that final
//   byte one result request leaves on the output channel (out_valid/out_ready)
//   carrying found, match_offset (offset of the matching element's id byte)
//   and overrun. Bytes that are not last produce no result.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register in
//   the cycle it is high; write only while no buffer is in flight.
// Pipeline and throughput
//   One byte per cycle sustained, unless a last byte meets a result that still
//   waits (see Stall). A byte is held in the input register, the scan state is
//   updated from it, and on the last byte the result register loads, raising
//   out_valid.
// Reset
//   rst_n clears the scan state, the configuration registers and both
//   valid flags asynchronously.
// Stall
//   While a result waits, non-last bytes keep flowing. A second last byte is
//   held in the input register until the waiting result is taken; in_ready
//   is low only while it is held.
module wlan_info_element_search (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [wies_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [wies_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           data_byte,
    input  wire logic                                 last_byte,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      found,
    output logic [wies_pkg::OFFSET_W-1:0]             match_offset,
    output logic                                      overrun
);

    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Configuration registers
    logic        match_mode_reg;
    logic [7:0]  target_id_reg;
    logic [23:0] target_oui_reg;
    logic [7:0]  target_oui_type_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Scan state
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        element_id_reg, element_id_next;
    logic [7:0]        body_left_reg, body_left_next;
    logic [7:0]        body_index_reg, body_index_next;
    wies_pkg::offset_t element_start_reg, element_start_next;
    wies_pkg::pos_t    byte_position_reg, byte_position_next;
    logic [31:0]       oui_capture_reg, oui_capture_next;
    logic              hit_flag_reg, hit_flag_next;
    wies_pkg::offset_t hit_offset_reg, hit_offset_next;
    logic              stopped_reg, stopped_next;
    logic              empty_pending_reg, empty_pending_next;
    logic              overrun_flag_reg, overrun_flag_next;

    // Result register
    logic              out_valid_reg;
    logic              found_reg;
    wies_pkg::offset_t match_offset_reg;
    logic              overrun_reg;

    logic advance;

    // A held last byte may only move on once the result slot is free.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    function automatic logic examine(
        input logic        mode,
        input logic [7:0]  tid,
        input logic [23:0] toui,
        input logic [7:0]  ttype,
        input logic [7:0]  eid,
        input logic [7:0]  idx,
        input logic [31:0] cap
    );
        logic hit;
        if (!mode)
            hit = (eid == tid);
        else
            hit = (eid == wies_pkg::VENDOR_SPEC_ID) && (idx >= wies_pkg::VENDOR_MIN_LEN)
                  && (cap == {toui, ttype});
        return hit;
    endfunction

    always_comb
    begin
        logic skip;
        phase_next         = phase_reg;
        element_id_next    = element_id_reg;
        body_left_next     = body_left_reg;
        body_index_next    = body_index_reg;
        element_start_next = element_start_reg;
        byte_position_next = byte_position_reg;
        oui_capture_next   = oui_capture_reg;
        hit_flag_next      = hit_flag_reg;
        hit_offset_next    = hit_offset_reg;
        stopped_next       = stopped_reg;
        empty_pending_next = empty_pending_reg;
        overrun_flag_next  = overrun_flag_reg;
        skip               = 1'b0;

        if (byte_position_reg >= wies_pkg::POS_W'(wies_pkg::MAX_BUFFER_BYTES))
        begin
            overrun_flag_next = 1'b1;
        end
        else
        begin
            byte_position_next = byte_position_reg + 1'b1;
            if (!stopped_reg)
            begin
                // Resolve an empty element now that a further byte has come.
                if (empty_pending_reg)
                begin
                    empty_pending_next = 1'b0;
                    body_index_next    = 8'd0;
                    oui_capture_next   = 32'd0;
                    if (examine(match_mode_reg, target_id_reg, target_oui_reg,
                                target_oui_type_reg, element_id_reg, 8'd0, 32'd0))
                    begin
                        hit_flag_next   = 1'b1;
                        hit_offset_next = element_start_reg;
                        stopped_next    = 1'b1;
                        skip            = 1'b1;
                    end
                end
                if (!skip)
                begin
                    case (phase_reg)
                        PH_LEN:
                        begin
                            if (in_byte_reg == 8'd0)
                            begin
                                empty_pending_next = 1'b1;
                                phase_next         = PH_ID;
                            end
                            else
                            begin
                                body_left_next   = in_byte_reg;
                                body_index_next  = 8'd0;
                                oui_capture_next = 32'd0;
                                phase_next       = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            if (body_index_reg < wies_pkg::VENDOR_HDR_LEN)
                                oui_capture_next = {oui_capture_reg[23:0], in_byte_reg};
                            body_index_next = body_index_reg + 8'd1;
                            body_left_next  = body_left_reg - 8'd1;
                            if (body_left_next == 8'd0)
                            begin
                                phase_next = PH_ID;
                                if (examine(match_mode_reg, target_id_reg, target_oui_reg,
                                            target_oui_type_reg, element_id_reg,
                                            body_index_next, oui_capture_next))
                                begin
                                    hit_flag_next   = 1'b1;
                                    hit_offset_next = element_start_reg;
                                    stopped_next    = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // Id byte; the unused phase code lands here too.
                            element_start_next = byte_position_reg[wies_pkg::OFFSET_W-1:0];
                            element_id_next    = in_byte_reg;
                            phase_next         = PH_LEN;
                        end
                    endcase
                end
            end
        end

        // Restart the scan after the last byte of a buffer.
        if (in_last_reg)
        begin
            phase_next         = PH_ID;
            element_id_next    = 8'd0;
            body_left_next     = 8'd0;
            body_index_next    = 8'd0;
            element_start_next = '0;
            byte_position_next = '0;
            oui_capture_next   = 32'd0;
            hit_flag_next      = 1'b0;
            hit_offset_next    = '0;
            stopped_next       = 1'b0;
            empty_pending_next = 1'b0;
            overrun_flag_next  = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_mode_reg      <= 1'b0;
            target_id_reg       <= 8'd0;
            target_oui_reg      <= 24'd0;
            target_oui_type_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wies_pkg::REG_MATCH_MODE: match_mode_reg      <= cfg_data[0];
                wies_pkg::REG_TARGET_ID:  target_id_reg       <= cfg_data[7:0];
                wies_pkg::REG_TARGET_OUI: target_oui_reg      <= cfg_data;
                wies_pkg::REG_OUI_TYPE:   target_oui_type_reg <= cfg_data[7:0];
                default:                  match_mode_reg      <= match_mode_reg;
            endcase
        end
    end

    // Input register: load on accept, drop once advanced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Scan state: advance once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_ID;
            element_id_reg    <= 8'd0;
            body_left_reg     <= 8'd0;
            body_index_reg    <= 8'd0;
            element_start_reg <= '0;
            byte_position_reg <= '0;
            oui_capture_reg   <= 32'd0;
            hit_flag_reg      <= 1'b0;
            hit_offset_reg    <= '0;
            stopped_reg       <= 1'b0;
            empty_pending_reg <= 1'b0;
            overrun_flag_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            element_id_reg    <= element_id_next;
            body_left_reg     <= body_left_next;
            body_index_reg    <= body_index_next;
            element_start_reg <= element_start_next;
            byte_position_reg <= byte_position_next;
            oui_capture_reg   <= oui_capture_next;
            hit_flag_reg      <= hit_flag_next;
            hit_offset_reg    <= hit_offset_next;
            stopped_reg       <= stopped_next;
            empty_pending_reg <= empty_pending_next;
            overrun_flag_reg  <= overrun_flag_next;
        end
    end

    // Result register: the outcome is taken from the state before the last
    // byte's restart, i.e. the _next values ahead of the clear.
    logic              res_hit;
    wies_pkg::offset_t res_offset;
    logic              res_overrun;

    always_comb
    begin
        res_hit     = hit_flag_reg;
        res_offset  = hit_offset_reg;
        res_overrun = overrun_flag_reg;
        if (byte_position_reg >= wies_pkg::POS_W'(wies_pkg::MAX_BUFFER_BYTES))
            res_overrun = 1'b1;
        else if (!stopped_reg && empty_pending_reg
                 && examine(match_mode_reg, target_id_reg, target_oui_reg,
                            target_oui_type_reg, element_id_reg, 8'd0, 32'd0))
        begin
            res_hit    = 1'b1;
            res_offset = element_start_reg;
        end
        else if (!stopped_reg && (phase_reg == PH_BODY) && (body_left_reg == 8'd1)
                 && examine(match_mode_reg, target_id_reg, target_oui_reg,
                            target_oui_type_reg, element_id_reg,
                            body_index_reg + 8'd1,
                            (body_index_reg < wies_pkg::VENDOR_HDR_LEN)
                                ? {oui_capture_reg[23:0], in_byte_reg}
                                : oui_capture_reg))
        begin
            res_hit    = 1'b1;
            res_offset = element_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            found_reg        <= res_hit;
            match_offset_reg <= res_hit ? res_offset : '0;
            overrun_reg      <= res_overrun;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = match_offset_reg;
    assign overrun      = overrun_reg;

endmodule

`default_nettype wire

// File: rtl/wies_checker.sv
// Port-level assertions for the information element search, with its bind.
`default_nettype none

module wies_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           last_byte,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic                           found,
    input wire logic [wies_pkg::OFFSET_W-1:0]  match_offset
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
        else $error("result dropped or changed while stalled");

    // No match means a zero offset.
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("offset set without a match");

    // Backpressure only comes from a waiting result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with a free result slot");

    // A fresh result follows an accepted last-byte request.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
        else $error("result without a last-byte request");

endmodule

bind wlan_info_element_search wies_checker u_wies_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset)
);

`default_nettype wire

// File: bench/wlan_info_element_search_tb.sv
// Self-checking testbench for the streamed 802.11 information element search block.
module wlan_info_element_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Random traffic volume and run bounds
    localparam int RANDOM_ITEMS  = 1800;
    localparam int QUIET_AFTER   = 1500;   // random bytes after which idling stops
    localparam int SETTLE_CYCLES = 6;      // idle margin after the last awaited result; allow margin
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {EXPECT_ID, EXPECT_LEN, IN_BODY} scan_phase_t;

    typedef struct packed {
        logic              found;
        wies_pkg::offset_t offset;
        logic              overrun;
    } search_result_t;

    // Scoreboard: a cycle-free model of the element scan plus the queue of results it predicts.
    class element_search_scoreboard;
        // Mirror of the configuration registers
        logic        mode;
        logic [7:0]  tgt_id;
        logic [23:0] tgt_oui;
        logic [7:0]  tgt_type;

        // Scan state of the buffer in progress
        scan_phase_t       ph;
        logic [7:0]        element_id;
        logic [7:0]        body_left;
        logic [7:0]        body_index;
        wies_pkg::offset_t element_start;
        int unsigned       byte_pos;
        logic [31:0]       oui_capture;
        logic              hit_flag;
        wies_pkg::offset_t hit_offset;
        logic              stopped;
        logic              empty_pending;
        logic              overrun_seen;

        search_result_t awaited[$];
        int unsigned    fail_count;

        function new();
            mode       = 1'b0;
            tgt_id     = '0;
            tgt_oui    = '0;
            tgt_type   = '0;
            fail_count = 0;
            clear_scan();
        endfunction

        function void set_targets(logic m, logic [7:0] tid, logic [23:0] oui, logic [7:0] otype);
            mode     = m;
            tgt_id   = tid;
            tgt_oui  = oui;
            tgt_type = otype;
        endfunction

        function void clear_scan();
            ph            = EXPECT_ID;
            element_id    = '0;
            body_left     = '0;
            body_index    = '0;
            element_start = '0;
            byte_pos      = 0;
            oui_capture   = '0;
            hit_flag      = 1'b0;
            hit_offset    = '0;
            stopped       = 1'b0;
            empty_pending = 1'b0;
            overrun_seen  = 1'b0;
        endfunction

        function void examine_element();
            logic hit;
            if (!mode)
                hit = (element_id == tgt_id);
            else
                hit = (element_id == wies_pkg::VENDOR_SPEC_ID)
                      && (body_index >= wies_pkg::VENDOR_MIN_LEN)
                      && (oui_capture == {tgt_oui, tgt_type});
            if (hit)
            begin
                hit_flag   = 1'b1;
                hit_offset = element_start;
                stopped    = 1'b1;
            end
        endfunction

        function void scan_byte(logic [7:0] b);
            // An empty element is judged only once a further byte shows it is complete
            if (empty_pending)
            begin
                empty_pending = 1'b0;
                body_index    = '0;
                oui_capture   = '0;
                examine_element();
                if (stopped)
                    return;
            end
            case (ph)
                EXPECT_LEN:
                begin
                    if (b == 8'd0)
                    begin
                        empty_pending = 1'b1;
                        ph            = EXPECT_ID;
                    end
                    else
                    begin
                        body_left   = b;
                        body_index  = '0;
                        oui_capture = '0;
                        ph          = IN_BODY;
                    end
                end
                IN_BODY:
                begin
                    if (body_index < wies_pkg::VENDOR_HDR_LEN)
                        oui_capture = {oui_capture[23:0], b};
                    body_index = body_index + 8'd1;
                    body_left  = body_left - 8'd1;
                    if (body_left == 8'd0)
                    begin
                        ph = EXPECT_ID;
                        examine_element();
                    end
                end
                default:
                begin
                    element_start = wies_pkg::offset_t'(byte_pos);
                    element_id    = b;
                    ph            = EXPECT_LEN;
                end
            endcase
        endfunction

        function void note_request(logic [7:0] b, logic is_last);
            search_result_t res;
            if (byte_pos >= wies_pkg::MAX_BUFFER_BYTES)
                overrun_seen = 1'b1;
            else
            begin
                if (!stopped)
                    scan_byte(b);
                byte_pos++;
            end
            if (is_last)
            begin
                res.found   = hit_flag;
                res.offset  = hit_flag ? hit_offset : '0;
                res.overrun = overrun_seen;
                awaited.push_back(res);
                clear_scan();
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            fail_count++;
        endtask

        task check_result(logic f, wies_pkg::offset_t off, logic ovr);
            search_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result found=%0b offset=%0d overrun=%0b",
                                 f, off, ovr));
                return;
            end
            want = awaited.pop_front();
            if (f !== want.found)
                report($sformatf("found %0b, expected %0b", f, want.found));
            if (off !== want.offset)
                report($sformatf("match_offset %0d, expected %0d", off, want.offset));
            if (ovr !== want.overrun)
                report($sformatf("overrun %0b, expected %0b", ovr, want.overrun));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [wies_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wies_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       data_byte;
    logic                             last_byte;
    logic                             out_valid;
    logic                             out_ready;
    logic                             found;
    wies_pkg::offset_t                match_offset;
    logic                             overrun;

    element_search_scoreboard scoreboard = new();

    // Buffer under construction, and the targets currently programmed
    logic [7:0]  frame[$];
    logic        cur_mode;
    logic [7:0]  cur_tid;
    logic [23:0] cur_oui;
    logic [7:0]  cur_type;

    bit          quiet_tail = 1'b0;
    int unsigned items_sent = 0;
    int          ready_hold = 0;

    wlan_info_element_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_offset (match_offset),
        .overrun      (overrun)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run finishes far inside this bound
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Sample both handshakes at the rising edge; note the request before
    // checking so that ordering within the step never matters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                scoreboard.note_request(data_byte, last_byte);
            if (out_valid && out_ready)
                scoreboard.check_result(found, match_offset, overrun);
        end
    end

    // Result side back-pressure: random low bursts, none in the tail
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
                ready_hold = $urandom_range(1, 5);
            out_ready <= (ready_hold == 0);
        end
    end

    // Present one byte request and hold it until the block takes it
    task automatic send_byte(input logic [7:0] value, input logic is_last, input bit gaps_on);
        if (gaps_on && !quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Stream the whole of frame, marking its final byte; some frames flow without gaps
    task automatic send_frame();
        bit gaps_on;
        gaps_on = ($urandom_range(0, 3) != 0);
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1, gaps_on);
    endtask

    // Wait for every awaited result, then let the pipeline settle
    task automatic wait_idle();
        while (scoreboard.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program all four registers back to back while nothing is in flight
    task automatic configure(input logic m, input logic [7:0] tid, input logic [23:0] oui,
                             input logic [7:0] otype);
        in_valid <= 1'b0;
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= wies_pkg::REG_MATCH_MODE;
        cfg_data  <= wies_pkg::CFG_DATA_W'(m);
        @(negedge clk);
        cfg_index <= wies_pkg::REG_TARGET_ID;
        cfg_data  <= wies_pkg::CFG_DATA_W'(tid);
        @(negedge clk);
        cfg_index <= wies_pkg::REG_TARGET_OUI;
        cfg_data  <= oui;
        @(negedge clk);
        cfg_index <= wies_pkg::REG_OUI_TYPE;
        cfg_data  <= wies_pkg::CFG_DATA_W'(otype);
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_mode = m;
        cur_tid  = tid;
        cur_oui  = oui;
        cur_type = otype;
        scoreboard.set_targets(m, tid, oui, otype);
    endtask

    function automatic void add_element(logic [7:0] id, int len);
        frame.push_back(id);
        frame.push_back(8'(len));
        repeat (len) frame.push_back(8'($urandom));
    endfunction

    // Vendor element whose first four body bytes carry hdr (OUI then type)
    function automatic void add_vendor(int len, logic [31:0] hdr);
        frame.push_back(wies_pkg::VENDOR_SPEC_ID);
        frame.push_back(8'(len));
        for (int k = 0; k < len; k++)
            frame.push_back(k < 4 ? hdr[31 - 8 * k -: 8] : 8'($urandom));
    endfunction

    // Mostly well-formed element chains with random content, biased towards
    // the current target; some end in a truncated element or loose noise.
    function automatic void build_random_frame();
        int          n_elem;
        int          pick;
        int          len;
        logic [31:0] hdr;
        frame.delete();
        hdr    = {cur_oui, cur_type};
        n_elem = $urandom_range(0, 5);
        repeat (n_elem)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 2)
            begin
                if (cur_mode)
                    add_vendor($urandom_range(4, 10), hdr);
                else
                    add_element(cur_tid, $urandom_range(0, 6));
            end
            else if (pick <= 4)
                add_vendor($urandom_range(0, 9), hdr ^ (32'd1 << $urandom_range(0, 31)));
            else if (pick == 5)
                add_element(cur_mode ? wies_pkg::VENDOR_SPEC_ID : cur_tid, 0);
            else
                add_element(8'($urandom), $urandom_range(0, 12));
        end
        pick = $urandom_range(0, 9);
        if (pick >= 8)
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        else if (pick >= 6)
        begin
            // Truncated element: the buffer ends before its body does
            frame.push_back($urandom_range(0, 1) ? cur_tid : 8'($urandom));
            if ($urandom_range(0, 3) != 0)
            begin
                len = $urandom_range(1, 255);
                frame.push_back(8'(len));
                repeat ($urandom_range(0, (len - 1 < 6) ? len - 1 : 6))
                    frame.push_back(8'($urandom));
            end
        end
        if (frame.size() == 0)
            frame.push_back(8'($urandom));
    endfunction

    initial
    begin
        int unsigned random_base;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: id matching
        configure(1'b0, 8'h30, 24'h0, 8'h00);
        // empty element followed by one more byte is examined and matches
        frame = '{8'h30, 8'h00, 8'h55};
        send_frame();
        // empty element closing the buffer is not examined
        frame = '{8'h30, 8'h00};
        send_frame();
        // lone id byte
        frame = '{8'h30};
        send_frame();
        // truncated element ends the search
        frame = '{8'h11, 8'h05, 8'hAA};
        send_frame();
        // match at offset 2; the bytes after it are ignored
        frame = '{8'hFF, 8'h00, 8'h30, 8'h01, 8'hFF, 8'h30};
        send_frame();

        // Directed: vendor matching
        configure(1'b1, 8'h00, 24'h0050F2, 8'h04);
        // vendor element too short to match
        frame = '{wies_pkg::VENDOR_SPEC_ID, 8'h04, 8'h00, 8'h50, 8'hF2, 8'h04};
        send_frame();
        // shortest vendor element that matches
        frame = '{wies_pkg::VENDOR_SPEC_ID, 8'h06, 8'h00, 8'h50, 8'hF2, 8'h04, 8'hAA, 8'hBB};
        send_frame();

        // Buffers at and beyond the maximum length: high offsets and overrun
        configure(1'b0, 8'h5A, 24'hA5A5A5, 8'h5A);
        for (int k = 0; k < 3; k++)
        begin
            frame.delete();
            repeat (16) add_element(8'h01, 253);
            case (k)
                0:
                begin
                    // match whose last byte is the final scanned byte, one byte of overrun
                    add_element(8'h01, 11);
                    add_element(8'h5A, 1);
                    frame.push_back(8'($urandom));
                end
                1:
                begin
                    // exactly the maximum length, ending in a truncated element
                    frame.push_back(8'h02);
                    frame.push_back(8'd20);
                    repeat (14) frame.push_back(8'($urandom));
                end
                default:
                begin
                    // target element straddling the length limit
                    add_element(8'h01, 12);
                    add_element(8'h5A, 5);
                end
            endcase
            send_frame();
        end

        // Random phases: the first four program the register extremes
        random_base = items_sent;
        for (int p = 0; items_sent - random_base < RANDOM_ITEMS; p++)
        begin
            case (p)
                0: configure(1'b0, 8'h00, 24'h000000, 8'h00);
                1: configure(1'b0, 8'hFF, 24'hFFFFFF, 8'hFF);
                2: configure(1'b1, 8'hFF, 24'h000000, 8'h00);
                3: configure(1'b1, 8'h00, 24'hFFFFFF, 8'hFF);
                default: configure(1'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
            endcase
            repeat ($urandom_range(10, 25))
            begin
                if (items_sent - random_base >= QUIET_AFTER)
                    quiet_tail = 1'b1;
                build_random_frame();
                send_frame();
            end
        end

        // Drain: drop valid, collect every awaited result, then settle
        in_valid <= 1'b0;
        quiet_tail = 1'b1;
        wait_idle();
        if (scoreboard.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
